@@ hw/rtl/mikl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mikl_pkg
// Shared types and constants for the mecanum inverse kinematics block.
// ----------------------------------------------------------------------------
package mikl_pkg;

  localparam int VelW   = 16;
  localparam int ArmW   = 16;
  localparam int GainW  = 24;
  localparam int LimW   = 15;
  localparam int MotW   = 16;
  localparam int QDepth = 2;

  // configuration register indexes
  localparam logic [1:0] RegArmSum   = 2'd0;
  localparam logic [1:0] RegGain     = 2'd1;
  localparam logic [1:0] RegMaxSpeed = 2'd2;

  // command handed from front to back
  typedef struct packed {
    logic                   stop;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic signed [VelW-1:0] wz;
  } cmd_t;

  typedef struct packed {
    logic                   action;
    logic signed [MotW-1:0] m4;
    logic signed [MotW-1:0] m3;
    logic signed [MotW-1:0] m2;
    logic signed [MotW-1:0] m1;
  } res_t;

endpackage

@@ hw/rtl/mikl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mikl_front
// Accepts commands, drops repeated stops, and queues work for the back end.
// ----------------------------------------------------------------------------
module mikl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mikl_pkg::cmd_t      in_cmd,
  output logic                q_valid,
  input  logic                q_ready,
  output mikl_pkg::cmd_t      q_cmd
);
  import mikl_pkg::*;

  cmd_t       mem [QDepth];
  cmd_t       push_cmd;
  logic       wptr, rptr;
  logic [1:0] count;
  logic       stopped_latch;
  logic       is_zero, push, pop, acc;

  assign in_ready = (count != 2'(QDepth));
  assign acc      = in_valid && in_ready;
  assign is_zero  = (in_cmd.vx == '0) && (in_cmd.vy == '0) && (in_cmd.wz == '0);
  // a zero command after a stop makes no work
  assign push     = acc && !(is_zero && stopped_latch);
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rptr];

  // queued command carries the stop flag
  always_comb begin
    push_cmd      = in_cmd;
    push_cmd.stop = is_zero;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= 2'd0; stopped_latch <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
      if (acc) stopped_latch <= is_zero;
    end
  end
endmodule

@@ hw/rtl/mikl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mikl_back
// Sequencer for one command: wheel sums, gain multiply, limit scaling with a
// shared restoring divider, and an output register.
// ----------------------------------------------------------------------------
module mikl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mikl_pkg::ArmW-1:0]   arm_sum,
  input  logic [mikl_pkg::GainW-1:0]  speed_gain,
  input  logic [mikl_pkg::LimW-1:0]   max_speed,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  mikl_pkg::cmd_t              q_cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mikl_pkg::res_t              out_res
);
  import mikl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROT  = 6'b000010,
    S_MUL  = 6'b000100,
    S_CHK  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t st;
  logic signed [VelW-1:0] vx, vy, wz;
  logic signed [32:0]     prod;
  logic signed [18:0]     wheel [4];
  logic signed [MotW-1:0] mot [4];
  logic [1:0]             idx;
  logic [15:0]            maxmag;
  logic [30:0]            rem;      // partial remainder
  logic [30:0]            num;      // dividend bits shifting out
  logic [14:0]            quo;
  logic [4:0]             bitc;
  logic signed [16:0]     rot;

  // multiply path: |wheel| * gain, one wheel per cycle
  logic signed [18:0] w_cur;
  logic [18:0]        w_mag;
  logic [42:0]        gprod;
  logic [22:0]        gq;
  logic [16:0]        sm;
  logic               sneg;
  logic signed [MotW-1:0] sv;
  logic [15:0]        sv_mag;
  logic [31:0]        rem_sh;
  logic signed [MotW-1:0] m_idx;
  logic [15:0]        m_idx_mag;
  logic [30:0]        sprod;

  assign rot   = 17'(prod >>> 16);
  assign w_cur = wheel[idx];
  assign w_mag = w_cur[18] ? 19'(-w_cur) : w_cur;
  assign gprod = 43'(w_mag) * 43'(speed_gain);
  assign gq    = gprod[42:20];
  // motors 2 and 4 negated
  assign sneg  = w_cur[18] ^ idx[0];
  assign sm    = (gq > 23'd32767) ? 17'd32768 : 17'(gq);
  always_comb begin
    if (sneg) sv = (sm == 17'd32768) ? -16'sd32768 : 16'(-sm);
    else sv = (sm == 17'd32768) ? 16'sd32767 : 16'(sm);
  end
  assign sv_mag    = sv[15] ? 16'(-sv) : 16'(sv);
  assign m_idx     = mot[idx];
  assign m_idx_mag = m_idx[15] ? 16'(-m_idx) : 16'(m_idx);
  assign rem_sh    = {rem, num[30]};
  // quotient never exceeds max_speed, so only the low 15 bits are worked out
  assign sprod     = 31'(m_idx_mag) * 31'(max_speed);

  assign q_ready = (st == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            if (q_cmd.stop) begin
              out_res   <= '0;
              out_valid <= 1'b1;
            end else begin
              vx <= q_cmd.vx; vy <= q_cmd.vy; wz <= q_cmd.wz;
              prod <= 33'($signed(q_cmd.wz)) * $signed({1'b0, arm_sum});
              st <= S_ROT;
            end
          end
        end
        S_ROT: begin
          wheel[0] <= 19'(vx) - 19'(vy) + 19'(rot);
          wheel[1] <= 19'(vx) + 19'(vy) - 19'(rot);
          wheel[2] <= 19'(vx) + 19'(vy) + 19'(rot);
          wheel[3] <= 19'(vx) - 19'(vy) - 19'(rot);
          idx <= 2'd0; maxmag <= '0;
          st <= S_MUL;
        end
        S_MUL: begin
          mot[idx] <= sv;
          if (sv_mag > maxmag) maxmag <= sv_mag;
          idx <= idx + 2'd1;
          if (idx == 2'd3) st <= S_CHK;
        end
        S_CHK: begin
          if (maxmag > 16'(max_speed)) begin
            // upper dividend bits are already below the divisor
            rem <= 31'(sprod[30:15]); num <= {sprod[14:0], 16'd0};
            bitc <= '0; st <= S_DIV;
          end else st <= S_OUT;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          num <= num << 1;
          if (rem_sh >= 32'(maxmag)) begin
            rem <= 31'(rem_sh - 32'(maxmag)); quo <= {quo[13:0], 1'b1};
          end else begin
            rem <= 31'(rem_sh); quo <= {quo[13:0], 1'b0};
          end
          bitc <= bitc + 5'd1;
          if (bitc == 5'd14) begin
            st <= S_CHK;
            mot[idx] <= m_idx[15] ? -16'({quo[13:0], (rem_sh >= 32'(maxmag))})
                                  : 16'({quo[13:0], (rem_sh >= 32'(maxmag))});
            if (idx == 2'd3) st <= S_OUT;
            idx <= idx + 2'd1;
          end
        end
        S_OUT: begin
          out_res   <= '{action: 1'b1, m4: mot[3], m3: mot[2], m2: mot[1], m1: mot[0]};
          out_valid <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/mecanum_inverse_kinematics_limit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_inverse_kinematics_limit_top
// Chassis velocity command to four limited mecanum motor speeds.
// ----------------------------------------------------------------------------
// Without limiting, a command passes the rotation, multiply, check and output
// states; when the speed limit applies, the four scalings run one after another
// through one restoring divider that works out 15 quotient bits at one bit
// per cycle. A two-entry queue lets the front take commands while the back
// end works. Repeated zero commands are dropped at the front and produce no
// result.
module mecanum_inverse_kinematics_limit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // vel_x, vel_y, omega_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // motor_one, motor_two, motor_three, motor_four
  output logic        m_tuser    // action
);
  import mikl_pkg::*;

  logic [ArmW-1:0]  arm_sum;
  logic [GainW-1:0] speed_gain;
  logic [LimW-1:0]  max_speed;
  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arm_sum <= 16'd10240; speed_gain <= 24'd1566000; max_speed <= 15'd8000;
    end else if (cfg_we) begin
      case (cfg_index)
        RegArmSum:   arm_sum    <= cfg_data[ArmW-1:0];
        RegGain:     speed_gain <= cfg_data;
        RegMaxSpeed: max_speed  <= cfg_data[LimW-1:0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{stop: 1'b0, vx: s_tdata[15:0], vy: s_tdata[31:16], wz: s_tdata[47:32]};

  mikl_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  mikl_back u_back (
    .clk, .rst, .arm_sum, .speed_gain, .max_speed,
    .q_valid, .q_ready, .q_cmd,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {res.m4, res.m3, res.m2, res.m1};
  assign m_tuser = res.action;

  // a stop result carries zero speeds
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0) else $error("stop with speeds");
  // a waiting result is held until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
endmodule

@@ verif/tb_mecanum_inverse_kinematics_limit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mecanum_inverse_kinematics_limit_top
// Self-checking testbench for the mecanum inverse kinematics block.
// Chassis commands go in through the input stream. Each accepted transaction
// is run through a local model of the wheel math, the gain, the saturation,
// the speed limit and the stop latch. Results that come out are checked in
// order, field by field. Random gaps are put on both streams. The gain, arm
// and limit registers are swept through several settings, the extremes among
// them. Each register write is made only while the block is idle.
// ----------------------------------------------------------------------------
module tb_mecanum_inverse_kinematics_limit_top;
  import mikl_pkg::*;

  localparam int IdleLimit  = 5000;
  localparam int DrainWait  = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = RegArmSum;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // vel_x, vel_y, omega_z
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // motor_one, motor_two, motor_three, motor_four
  logic        m_tuser;        // action

  mecanum_inverse_kinematics_limit_top uut (.*);

  always #1 clk = ~clk;

  // local copy of registers and stop latch
  logic [ArmW-1:0]  arm_q;
  logic [GainW-1:0] gain_q;
  logic [LimW-1:0]  limit_q;
  bit               stop_sent;

  res_t motor_q[$];
  int   mismatches = 0;
  bit   no_idle = 1'b0;
  int   idle_cycles = 0;

  // wheel speeds for one command; returns 0 when no result is due
  function automatic bit wheel_speeds(input logic signed [15:0] vx, vy, wz,
                                      output res_t r);
    longint yaw, w[4], mot[4], mag, q, peak;
    peak = 0;
    r = '0;
    if (vx == 0 && vy == 0 && wz == 0) begin
      if (stop_sent) return 1'b0;
      stop_sent = 1'b1;
      return 1'b1;
    end
    stop_sent = 1'b0;
    yaw = (longint'(wz) * longint'({1'b0, arm_q})) >>> 16;
    w[0] = vx - vy + yaw;
    w[1] = vx + vy - yaw;
    w[2] = vx + vy + yaw;
    w[3] = vx - vy - yaw;
    for (int i = 0; i < 4; i++) begin
      mag = (w[i] < 0) ? -w[i] : w[i];
      q = (mag * longint'({1'b0, gain_q})) >> 20;
      if (w[i] < 0) q = -q;
      if (i == 1 || i == 3) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      mot[i] = q;
      mag = (q < 0) ? -q : q;
      if (mag > peak) peak = mag;
    end
    if (peak > longint'(limit_q)) begin
      for (int i = 0; i < 4; i++) begin
        mag = (mot[i] < 0) ? -mot[i] : mot[i];
        q = (mag * longint'(limit_q)) / peak;
        mot[i] = (mot[i] < 0) ? -q : q;
      end
    end
    r.action = 1'b1;
    r.m1 = mot[0][15:0];
    r.m2 = mot[1][15:0];
    r.m3 = mot[2][15:0];
    r.m4 = mot[3][15:0];
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // send one command, predict once accepted
  task automatic send_cmd(input logic [15:0] vx, vy, wz);
    res_t r;
    int g;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {wz, vy, vx};
    do @(posedge clk); while (!s_tready);
    if (wheel_speeds(vx, vy, wz, r)) motor_q.push_back(r);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (motor_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegArmSum:   arm_q   = val[ArmW-1:0];
      RegGain:     gain_q  = val[GainW-1:0];
      RegMaxSpeed: limit_q = val[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_random();
    int k;
    logic [15:0] a, b, c;
    k = $urandom_range(99);
    a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
    if (k < 8) begin
      a = '0; b = '0; c = '0;
    end else if (k < 40) begin
      a = 16'($signed($urandom_range(400)) - 200);
      b = 16'($signed($urandom_range(400)) - 200);
      c = 16'($signed($urandom_range(800)) - 400);
    end else if (k < 50) begin
      a = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
      b = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
      c = ($urandom_range(1)) ? 16'h7fff : 16'h8000;
    end
    send_cmd(a, b, c);
  endtask

  task automatic test_directed();
    send_cmd(16'd0, 16'd0, 16'd0);         // first stop
    send_cmd(16'd0, 16'd0, 16'd0);         // repeated zero, dropped
    send_cmd(16'd1, 16'd0, 16'd0);         // tiny speed gives unit motor speeds
    send_cmd(16'd0, 16'd0, 16'd0);
    send_cmd(16'h7fff, 16'd0, 16'd0);
    send_cmd(16'h8000, 16'd0, 16'd0);
    send_cmd(16'd0, 16'h7fff, 16'd0);
    send_cmd(16'd0, 16'h8000, 16'd0);
    send_cmd(16'd0, 16'd0, 16'h7fff);
    send_cmd(16'd0, 16'd0, 16'h8000);
    send_cmd(16'd0, 16'd0, 16'hffff);      // yaw term rounds down
    send_cmd(16'h8000, 16'h7fff, 16'h8000);
    send_cmd(16'h7fff, 16'h8000, 16'h7fff);
    send_cmd(16'sd100, -16'sd50, 16'sd300);
    send_cmd(-16'sd100, 16'sd60, -16'sd700);
  endtask

  // negation overflow and zero limit
  task automatic test_edges();
    write_reg(RegGain, 24'hffffff);
    write_reg(RegMaxSpeed, 24'h007fff);
    send_cmd(16'h8000, 16'd0, 16'd0);
    send_cmd(16'h8000, 16'h8000, 16'd0);
    send_cmd(16'h7fff, 16'h7fff, 16'h7fff);
    write_reg(RegMaxSpeed, 24'd0);
    send_cmd(16'h0100, 16'h0020, 16'h0300);
    send_cmd(16'd0, 16'd0, 16'd0);
    send_cmd(16'd5, 16'd0, 16'd0);
  endtask

  task automatic test_random_phase(input int n, input logic [15:0] arm,
                                   input logic [23:0] gain, input logic [14:0] lim);
    write_reg(RegArmSum, 24'(arm));
    write_reg(RegGain, gain);
    write_reg(RegMaxSpeed, 24'(lim));
    for (int i = 0; i < n; i++) send_random();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 150; i++) send_random();
    no_idle = 1'b0;
    wait_drained();
  endtask

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (motor_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: action=%0d data=%h", m_tuser, m_tdata);
      end else begin
        e = motor_q.pop_front();
        if (m_tuser !== e.action || m_tdata[15:0] !== e.m1 ||
            m_tdata[31:16] !== e.m2 || m_tdata[47:32] !== e.m3 ||
            m_tdata[63:48] !== e.m4) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp action=%0d m=%0d %0d %0d %0d,",
                      " got action=%0d m=%0d %0d %0d %0d"},
                     e.action, e.m1, e.m2, e.m3, e.m4, m_tuser,
                     $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                     $signed(m_tdata[47:32]), $signed(m_tdata[63:48]));
        end
      end
    end
  end

  // receiver stalls
  int stall_left = 0;
  always @(negedge clk) begin
    if (no_idle) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      m_tready <= 1'b1;
    end
  end

  // watchdog on transaction activity
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("mecanum_inverse_kinematics_limit_top verification failed");
      $finish;
    end
  end

  initial begin
    arm_q = 16'd10240; gain_q = 24'd1566000; limit_q = 15'd8000; stop_sent = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_edges();
    test_random_phase(500, 16'd10240, 24'd1566000, 15'd8000);
    test_random_phase(300, 16'd0, 24'd65536, 15'h7fff);
    test_random_phase(300, 16'hffff, 24'd4000, 15'd1000);
    test_random_phase(200, 16'd5000, 24'd0, 15'd100);
    test_random_phase(250, 16'd20000, 24'hffffff, 15'd1);
    test_back_to_back();
    test_random_phase(200, 16'd777, 24'd300000, 15'd30000);
    wait_drained();
    if (mismatches == 0 && motor_q.size() == 0)
      $display("mecanum_inverse_kinematics_limit_top verification clean");
    else
      $display("mecanum_inverse_kinematics_limit_top verification failed");
    $finish;
  end

endmodule
